FILE: hdl/fwrle_pkg.sv
// Shared types, constants and slot arithmetic for the frame window RLE pixel writer.
`timescale 1ns / 1ps

package fwrle_pkg;

    localparam int FRAME_SLOTS  = 5;
    localparam int LINE_PIXELS  = 640;
    localparam int FRAME_LINES  = 480;
    localparam int FRAME_TOTAL  = LINE_PIXELS * FRAME_LINES;

    localparam int SLOT_IDX_W   = $clog2(FRAME_SLOTS);
    localparam int K_W          = $clog2(FRAME_SLOTS + 1);
    localparam int OUT_SLOT_W   = 3;
    localparam int PIX_W        = 19;
    localparam int PCOUNT_W     = 24;
    localparam int CNT_W        = 16;
    localparam int OUT_DATA_W   = 128;

    localparam logic [7:0]       MARKER_BYTE  = 8'h42;
    localparam logic [31:0]      FILL_RESTART = 32'hFF000000;
    localparam logic [CNT_W-1:0] CNT_MAX      = 16'hFFFF;

    // Header modes carried in bits 31..30 of the offset word
    localparam logic [1:0] MODE_SINGLE = 2'd0;
    localparam logic [1:0] MODE_RLE    = 2'd1;
    localparam logic [1:0] MODE_BAD_2  = 2'd2;
    localparam logic [1:0] MODE_BAD_3  = 2'd3;

    typedef enum logic [1:0] {
        PH_FRAME,
        PH_OFFSET,
        PH_DATA
    } phase_t;

    typedef enum logic [2:0] {
        KIND_RUN   = 3'd0,
        KIND_CLEAR = 3'd1,
        KIND_SHOW  = 3'd2,
        KIND_DROP  = 3'd3,
        KIND_ERROR = 3'd4
    } out_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_SHORT     = 3'd1,
        ERR_OFFSCREEN = 3'd2,
        ERR_MODE      = 3'd3,
        ERR_MARKER    = 3'd4
    } err_code_t;

    typedef enum logic [2:0] {
        EV_RUN,
        EV_ERR,
        EV_DROP,
        EV_RESTART,
        EV_ADVANCE
    } ev_kind_t;

    // One request's worth of results, in compact form; the emitter expands it.
    typedef struct packed {
        ev_kind_t              kind;
        logic [SLOT_IDX_W-1:0] base;
        logic [K_W-1:0]        k;
        logic [OUT_SLOT_W-1:0] slot;
        logic [PIX_W-1:0]      pix;
        logic [PIX_W-1:0]      len;
        logic [31:0]           value;
        logic [31:0]           frame;
        logic [CNT_W-1:0]      total;
        err_code_t             err;
    } fwrle_ev_t;

    // Physical slot of a logical slot: (base + l) mod FRAME_SLOTS, l <= FRAME_SLOTS.
    function automatic logic [SLOT_IDX_W-1:0] phys(input logic [SLOT_IDX_W-1:0] base,
                                                   input logic [K_W-1:0] l);
        logic [K_W:0] s;
        s = (K_W+1)'(base) + (K_W+1)'(l);
        if (s >= (K_W+1)'(FRAME_SLOTS)) begin
            s = s - (K_W+1)'(FRAME_SLOTS);
        end
        return s[SLOT_IDX_W-1:0];
    endfunction

endpackage

FILE: hdl/frame_window_rle_pixel_writer.sv
// Top level of the frame window RLE pixel writer: stream ports around parser and emitter.
`timescale 1ns / 1ps
// A request's results pass through the event register and then the output register to m_.
// Throughput: one request per cycle while the event register is empty or drains; a pixel
// word or marker makes at most one result. A header that restarts the window emits
// FRAME_SLOTS clears, an advance by k slots a show and k clears; new requests wait for the last.
// Reset: aresetn is synchronous, active low; it empties the window (frame 0 in slot 0),
// zeroes all packet counts and drops any event or result in flight.

module frame_window_rle_pixel_writer (
    input  logic         aclk,
    input  logic         aresetn,
    // Request stream: one packet word per request
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // [31:0] packet_word
    input  logic         s_tuser,   // [0] packet_start
    input  logic         s_tlast,   // packet_end
    // Result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [2:0] slot, [21:3] pixel_index, [40:22] run_length,
                                    // [72:41] pixel_value, [104:73] frame_number,
                                    // [120:105] packet_total, [123:121] error_code,
                                    // [127:124] zero
    output logic [2:0]   m_tuser,   // [2:0] kind
    output logic         m_tlast    // last_of_run
);
    import fwrle_pkg::*;

    logic       acc;
    logic       ev_valid;
    logic       ev_ready;
    fwrle_ev_t  ev;

    // Take a request whenever the event register is empty or drains this cycle;
    // a request that makes no result still updates the parser state.
    assign s_tready = ev_ready;
    assign acc      = s_tvalid && ev_ready;

    // Parse the word, move the window and build at most one event
    fwrle_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .acc      (acc),
        .word     (s_tdata),
        .start    (s_tuser),
        .last     (s_tlast),
        .ev_valid (ev_valid),
        .ev       (ev)
    );

    // Hold the event and drive its results one per cycle, as the output register frees up, into it
    fwrle_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ev_valid (ev_valid),
        .ev       (ev),
        .ev_ready (ev_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: hdl/fwrle_ctrl.sv
// Packet parser and frame window state; turns each accepted word into at most one event.
`timescale 1ns / 1ps

module fwrle_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               acc,
    input  logic [31:0]        word,
    input  logic               start,
    input  logic               last,
    output logic               ev_valid,
    output fwrle_pkg::fwrle_ev_t ev
);
    import fwrle_pkg::*;

    typedef enum logic [3:0] {
        ACT_IDLE,
        ACT_FRAME,
        ACT_SHORT,
        ACT_OFFERR,
        ACT_DROP,
        ACT_OPEN,
        ACT_RUN,
        ACT_MARK,
        ACT_MARKERR
    } act_t;

    phase_t                phase_reg, phase_next;
    logic [31:0]           frame_reg, frame_next;
    logic [1:0]            mode_reg, mode_next;
    logic [PIX_W-1:0]      wp_reg, wp_next;
    logic [31:0]           wl_reg, wl_next;
    logic [SLOT_IDX_W-1:0] base_reg, base_next;
    logic [SLOT_IDX_W-1:0] active_reg, active_next;
    logic [CNT_W-1:0]      counts_reg [FRAME_SLOTS];
    logic [CNT_W-1:0]      counts_next [FRAME_SLOTS];
    logic                  pend_reg, pend_next;
    logic [PCOUNT_W-1:0]   pcount_reg, pcount_next;
    logic                  disc_reg, disc_next;

    // Decode signals
    act_t                  act;
    err_code_t             off_err;
    phase_t                phase_e;
    logic                  disc_e;
    logic                  pend_e;
    logic [27:0]           pix;
    logic                  restart;
    logic [31:0]           wl_eff;
    logic                  advance;
    logic                  old_frame;
    logic [31:0]           new_low;
    logic [31:0]           kfull;
    logic [K_W-1:0]        k;
    logic [31:0]           wl_new;
    logic [SLOT_IDX_W-1:0] base_new;
    logic [31:0]           rel;
    logic [SLOT_IDX_W-1:0] active_new;
    logic [SLOT_IDX_W-1:0] show_slot;
    logic [PCOUNT_W-1:0]   run_count;
    logic [PIX_W-1:0]      room;
    logic                  run_ok;
    logic [PIX_W-1:0]      run_len;

    always_comb begin
        phase_e    = start ? PH_FRAME : phase_reg;
        disc_e     = start ? 1'b0 : disc_reg;
        pend_e     = start ? 1'b0 : pend_reg;
        pix        = word[29:2];

        // A restart (frame 1) can never advance or drop, so compare against the old low
        restart    = (wl_reg > 32'd1) && (frame_reg == 32'd1);
        wl_eff     = restart ? 32'd0 : wl_reg;
        advance    = {1'b0, frame_reg} >= ({1'b0, wl_reg} + 33'(FRAME_SLOTS));
        old_frame  = !restart && !advance && (frame_reg < wl_reg);
        new_low    = frame_reg + 32'd1 - 32'(FRAME_SLOTS);
        kfull      = new_low - wl_reg;
        k          = (kfull > 32'(FRAME_SLOTS)) ? K_W'(FRAME_SLOTS) : kfull[K_W-1:0];
        wl_new     = advance ? new_low : wl_eff;
        base_new   = advance ? phys(base_reg, k) : base_reg;
        rel        = advance ? 32'(FRAME_SLOTS - 1) :
                     (restart ? 32'd1 : frame_reg - wl_reg);
        active_new = phys(base_new, rel[K_W-1:0]);
        show_slot  = phys(base_reg, k - K_W'(1));

        run_count  = ((mode_reg != MODE_SINGLE) && pend_e) ? pcount_reg : PCOUNT_W'(1);
        room       = PIX_W'(FRAME_TOTAL) - wp_reg;
        run_ok     = (wp_reg < PIX_W'(FRAME_TOTAL)) && (run_count != '0);
        run_len    = (run_count < PCOUNT_W'(room)) ? run_count[PIX_W-1:0] : room;

        act     = ACT_IDLE;
        off_err = ERR_NONE;
        if (!disc_e) begin
            case (phase_e)
                PH_FRAME: begin
                    act = last ? ACT_SHORT : ACT_FRAME;
                end
                PH_OFFSET: begin
                    if (pix >= 28'(FRAME_TOTAL)) begin
                        act     = ACT_OFFERR;
                        off_err = ERR_OFFSCREEN;
                    end else if (word[31:30] > MODE_RLE) begin
                        act     = ACT_OFFERR;
                        off_err = ERR_MODE;
                    end else if (old_frame) begin
                        act = ACT_DROP;
                    end else begin
                        act = ACT_OPEN;
                    end
                end
                default: begin
                    if (mode_reg == MODE_SINGLE || pend_e) begin
                        act = ACT_RUN;
                    end else if (word[7:0] == MARKER_BYTE) begin
                        act = last ? ACT_MARKERR : ACT_MARK;
                    end else begin
                        act = ACT_RUN;
                    end
                end
            endcase
        end
    end

    // Next state
    always_comb begin
        phase_next  = phase_reg;
        frame_next  = frame_reg;
        mode_next   = mode_reg;
        wp_next     = wp_reg;
        wl_next     = wl_reg;
        base_next   = base_reg;
        active_next = active_reg;
        pend_next   = pend_reg;
        pcount_next = pcount_reg;
        disc_next   = disc_reg;
        if (acc) begin
            phase_next = phase_e;
            disc_next  = disc_e;
            pend_next  = pend_e;
            if (disc_e && last) begin
                disc_next  = 1'b0;
                phase_next = PH_FRAME;
                pend_next  = 1'b0;
            end
            case (act)
                ACT_FRAME: begin
                    frame_next = word;
                    phase_next = PH_OFFSET;
                end
                ACT_SHORT: begin
                    frame_next = word;
                    phase_next = PH_FRAME;
                    pend_next  = 1'b0;
                    disc_next  = 1'b0;
                end
                ACT_OFFERR, ACT_DROP: begin
                    phase_next = PH_FRAME;
                    pend_next  = 1'b0;
                    disc_next  = !last;
                end
                ACT_OPEN: begin
                    wl_next     = wl_new;
                    base_next   = base_new;
                    active_next = active_new;
                    wp_next     = pix[PIX_W-1:0];
                    mode_next   = word[31:30];
                    pend_next   = 1'b0;
                    phase_next  = last ? PH_FRAME : PH_DATA;
                end
                ACT_RUN: begin
                    pend_next = 1'b0;
                    if (run_ok) begin
                        wp_next = wp_reg + run_len;
                    end
                    if (last) begin
                        phase_next = PH_FRAME;
                    end
                end
                ACT_MARK: begin
                    pcount_next = word[31:8];
                    pend_next   = 1'b1;
                end
                ACT_MARKERR: begin
                    pcount_next = word[31:8];
                    pend_next   = 1'b0;
                    phase_next  = PH_FRAME;
                    disc_next   = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Per-slot packet counters: clear recycled slots, then count the opened packet
    always_comb begin
        for (int j = 0; j < FRAME_SLOTS; j++) begin
            logic [SLOT_IDX_W-1:0] js;
            logic [K_W:0]          lj;
            logic                  clr;
            logic [CNT_W-1:0]      c;
            js  = SLOT_IDX_W'(j);
            lj  = (js >= base_reg) ? (K_W+1)'(js - base_reg)
                                   : (K_W+1)'(j + FRAME_SLOTS) - (K_W+1)'(base_reg);
            clr = acc && (act == ACT_OPEN) && (restart || (advance && lj < (K_W+1)'(k)));
            c   = clr ? '0 : counts_reg[j];
            if (acc && act == ACT_OPEN && js == active_new && c != CNT_MAX) begin
                c = c + CNT_W'(1);
            end
            counts_next[j] = c;
        end
    end

    // Event output
    always_comb begin
        ev       = '0;
        ev.kind  = EV_RUN;
        ev.err   = ERR_NONE;
        ev_valid = 1'b0;
        case (act)
            ACT_SHORT: begin
                ev_valid = acc;
                ev.kind  = EV_ERR;
                ev.err   = ERR_SHORT;
            end
            ACT_OFFERR: begin
                ev_valid = acc;
                ev.kind  = EV_ERR;
                ev.err   = off_err;
            end
            ACT_MARKERR: begin
                ev_valid = acc;
                ev.kind  = EV_ERR;
                ev.err   = ERR_MARKER;
            end
            ACT_DROP: begin
                ev_valid = acc;
                ev.kind  = EV_DROP;
                ev.frame = frame_reg;
            end
            ACT_OPEN: begin
                ev.base = base_reg;
                if (restart) begin
                    ev_valid = acc;
                    ev.kind  = EV_RESTART;
                end else if (advance) begin
                    ev_valid = acc;
                    ev.kind  = EV_ADVANCE;
                    ev.k     = k;
                    ev.slot  = OUT_SLOT_W'(show_slot);
                    ev.frame = wl_eff + 32'(k) - 32'd1;
                    ev.total = counts_reg[show_slot];
                end
            end
            ACT_RUN: begin
                ev_valid = acc && run_ok;
                ev.kind  = EV_RUN;
                ev.slot  = OUT_SLOT_W'(active_reg);
                ev.pix   = wp_reg;
                ev.len   = run_len;
                ev.value = word;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_FRAME;
            frame_reg  <= '0;
            mode_reg   <= '0;
            wp_reg     <= '0;
            wl_reg     <= '0;
            base_reg   <= '0;
            active_reg <= '0;
            pend_reg   <= 1'b0;
            pcount_reg <= '0;
            disc_reg   <= 1'b0;
            for (int j = 0; j < FRAME_SLOTS; j++) begin
                counts_reg[j] <= '0;
            end
        end else begin
            phase_reg  <= phase_next;
            frame_reg  <= frame_next;
            mode_reg   <= mode_next;
            wp_reg     <= wp_next;
            wl_reg     <= wl_next;
            base_reg   <= base_next;
            active_reg <= active_next;
            pend_reg   <= pend_next;
            pcount_reg <= pcount_next;
            disc_reg   <= disc_next;
            for (int j = 0; j < FRAME_SLOTS; j++) begin
                counts_reg[j] <= counts_next[j];
            end
        end
    end

    a_wp_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        wp_reg <= PIX_W'(FRAME_TOTAL))
        else $error("write position past frame end");

    a_slots_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (base_reg < SLOT_IDX_W'(FRAME_SLOTS)) && (active_reg < SLOT_IDX_W'(FRAME_SLOTS)))
        else $error("slot pointer out of range");

    a_pend_in_data: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (phase_reg == PH_DATA) && !disc_reg)
        else $error("pending repeat outside data phase");

endmodule

FILE: hdl/fwrle_emit.sv
// Event register and result expander with the registered output stage.
`timescale 1ns / 1ps

module fwrle_emit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         ev_valid,
    input  fwrle_pkg::fwrle_ev_t         ev,
    output logic                         ev_ready,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [fwrle_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [2:0]                   m_tuser,
    output logic                         m_tlast
);
    import fwrle_pkg::*;

    fwrle_ev_t              ev_reg;
    logic                   ev_valid_reg, ev_valid_next;
    logic [K_W-1:0]         idx_reg, idx_next;

    logic                   m_valid_reg, m_valid_next;
    out_kind_t              kind_reg, kind_next;
    logic [OUT_SLOT_W-1:0]  slot_reg, slot_next;
    logic [PIX_W-1:0]       pix_reg, pix_next;
    logic [PIX_W-1:0]       len_reg, len_next;
    logic [31:0]            value_reg, value_next;
    logic [31:0]            frame_reg, frame_next;
    logic [CNT_W-1:0]       total_reg, total_next;
    err_code_t              err_reg, err_next;
    logic                   last_reg, last_next;

    logic                   load_out;
    logic                   is_last;
    logic                   done;

    // Expand the held event at the current index
    always_comb begin
        kind_next  = KIND_RUN;
        slot_next  = '0;
        pix_next   = '0;
        len_next   = '0;
        value_next = '0;
        frame_next = '0;
        total_next = '0;
        err_next   = ERR_NONE;
        is_last    = 1'b1;
        case (ev_reg.kind)
            EV_RUN: begin
                kind_next  = KIND_RUN;
                slot_next  = ev_reg.slot;
                pix_next   = ev_reg.pix;
                len_next   = ev_reg.len;
                value_next = ev_reg.value;
            end
            EV_ERR: begin
                kind_next = KIND_ERROR;
                err_next  = ev_reg.err;
            end
            EV_DROP: begin
                kind_next  = KIND_DROP;
                frame_next = ev_reg.frame;
            end
            EV_RESTART: begin
                kind_next  = KIND_CLEAR;
                slot_next  = OUT_SLOT_W'(phys(ev_reg.base, idx_reg));
                value_next = FILL_RESTART;
                is_last    = idx_reg == K_W'(FRAME_SLOTS - 1);
            end
            EV_ADVANCE: begin
                is_last = idx_reg == ev_reg.k;
                if (idx_reg == '0) begin
                    kind_next  = KIND_SHOW;
                    slot_next  = ev_reg.slot;
                    frame_next = ev_reg.frame;
                    total_next = ev_reg.total;
                end else begin
                    kind_next = KIND_CLEAR;
                    slot_next = OUT_SLOT_W'(phys(ev_reg.base, idx_reg - K_W'(1)));
                end
            end
            default: begin
            end
        endcase
        last_next = is_last;
    end

    // Advance through the event as the output stage frees up
    always_comb begin
        load_out      = ev_valid_reg && (!m_valid_reg || m_tready);
        done          = load_out && is_last;
        ev_ready      = !ev_valid_reg || done;
        ev_valid_next = ev_valid ? 1'b1 : (done ? 1'b0 : ev_valid_reg);
        idx_next      = idx_reg;
        if (ev_valid) begin
            idx_next = '0;
        end else if (load_out && !is_last) begin
            idx_next = idx_reg + K_W'(1);
        end
        m_valid_next = load_out ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ev_valid_reg <= 1'b0;
            idx_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            ev_valid_reg <= ev_valid_next;
            idx_reg      <= idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ev_valid) begin
            ev_reg <= ev;
        end
        if (load_out) begin
            kind_reg  <= kind_next;
            slot_reg  <= slot_next;
            pix_reg   <= pix_next;
            len_reg   <= len_next;
            value_reg <= value_next;
            frame_reg <= frame_next;
            total_reg <= total_next;
            err_reg   <= err_next;
            last_reg  <= last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {4'b0, err_reg, total_reg, frame_reg, value_reg,
                       len_reg, pix_reg, slot_reg};

    a_err_code_matches_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((kind_reg == KIND_ERROR) == (err_reg != ERR_NONE)))
        else $error("error code and result kind disagree");

    a_run_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && kind_reg == KIND_RUN) |->
            (len_reg != '0) && ((20'(pix_reg) + 20'(len_reg)) <= 20'(FRAME_TOTAL)))
        else $error("write run empty or past frame end");

    a_idx_in_event: assert property (@(posedge aclk) disable iff (!aresetn)
        ev_valid_reg |-> ((ev_reg.kind == EV_ADVANCE && idx_reg <= ev_reg.k) ||
                          (ev_reg.kind == EV_RESTART && idx_reg < K_W'(FRAME_SLOTS)) ||
                          idx_reg == '0))
        else $error("result index past end of event");

    a_no_event_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (ev_valid_reg && !done) |-> !ev_valid)
        else $error("event register overwritten before fully emitted");

endmodule

FILE: tb/frame_window_rle_pixel_writer_test.sv
// Self-checking testbench for the frame window RLE pixel writer: stream driver, monitor, predictor.
`timescale 1ns / 1ps

module frame_window_rle_pixel_writer_test;

    import fwrle_pkg::*;

    localparam int RANDOM_REQUESTS = 280;
    localparam int HOLD_AFTER      = 120;   // requests taken before the long receiver hold
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 20;    // covers a restart plus the output register
    localparam int CYCLE_LIMIT     = 100000;
    localparam int PRINT_LIMIT     = 30;

    typedef struct {
        logic [31:0] word;
        logic        start;
        logic        fin;
    } packet_word_t;

    typedef struct {
        out_kind_t   kind;
        logic [2:0]  slot;
        logic [18:0] pix;
        logic [18:0] len;
        logic [31:0] value;
        logic [31:0] frame;
        logic [15:0] total;
        err_code_t   err;
        logic        last;
    } pixel_result_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata  = 32'd0;
    logic         s_tuser  = 1'b0;
    logic         s_tlast  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;

    frame_window_rle_pixel_writer uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    // Hold reset low at the start, then release it on a falling edge
    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    packet_word_t  pending_words[$];
    pixel_result_t expected_results[$];
    pixel_result_t step_results[$];

    int unsigned cycle_count   = 0;
    int unsigned req_count     = 0;
    int unsigned results_seen  = 0;
    int unsigned mismatches    = 0;
    int unsigned kind_seen[5]  = '{default: 0};
    logic [31:0] frame_cursor  = 32'd10;
    bit          req_taken     = 1'b0;

    // ------------------------------------------------------------------
    // Predictor state: mirrors the writer's parser and frame window
    // ------------------------------------------------------------------
    phase_t      phase       = PH_FRAME;
    logic [31:0] cur_frame   = '0;
    logic [1:0]  pkt_mode    = MODE_SINGLE;
    logic [18:0] wpos        = '0;
    logic [31:0] win_low     = '0;
    logic [2:0]  slot_base   = '0;
    logic [2:0]  active_slot = '0;
    logic [15:0] slot_counts[FRAME_SLOTS] = '{default: '0};
    bit          run_pend    = 1'b0;
    logic [23:0] pend_count  = '0;
    bit          discard     = 1'b0;

    function automatic logic [2:0] slot_of(input int unsigned logical);
        return 3'((slot_base + logical) % FRAME_SLOTS);
    endfunction

    function automatic void queue_result(input out_kind_t kind, input logic [2:0] slot,
                                         input logic [18:0] pix, input logic [18:0] len,
                                         input logic [31:0] value, input logic [31:0] frame,
                                         input logic [15:0] total, input err_code_t err);
        pixel_result_t r;
        r.kind  = kind;
        r.slot  = slot;
        r.pix   = pix;
        r.len   = len;
        r.value = value;
        r.frame = frame;
        r.total = total;
        r.err   = err;
        r.last  = 1'b0;
        step_results.push_back(r);
    endfunction

    // Write a run at the current position; clip it at the frame end, skip it if empty
    function automatic void run_pixels(input logic [23:0] count, input logic [31:0] value);
        int unsigned room;
        int unsigned len;
        if (wpos >= FRAME_TOTAL || count == 0) return;
        room = FRAME_TOTAL - wpos;
        len  = (count < room) ? count : room;
        queue_result(KIND_RUN, active_slot, wpos, 19'(len), value, '0, '0, ERR_NONE);
        wpos = wpos + 19'(len);
    endfunction

    function automatic void raise_error(input err_code_t code, input bit fin);
        queue_result(KIND_ERROR, '0, '0, '0, '0, '0, '0, code);
        phase    = PH_FRAME;
        run_pend = 1'b0;
        discard  = !fin;
    endfunction

    // Work out every result one accepted packet word causes and queue them up
    task automatic track_packet_word(input packet_word_t w);
        logic [1:0]  mode;
        logic [27:0] pix;
        logic [31:0] new_low;
        logic [31:0] span;
        logic [2:0]  p;
        bit          taken;
        step_results.delete();
        if (w.start) begin
            phase    = PH_FRAME;
            discard  = 1'b0;
            run_pend = 1'b0;
        end
        if (discard) begin
            if (w.fin) begin
                discard  = 1'b0;
                phase    = PH_FRAME;
                run_pend = 1'b0;
            end
        end else if (phase == PH_FRAME) begin
            cur_frame = w.word;
            if (w.fin) raise_error(ERR_SHORT, 1'b1);
            else phase = PH_OFFSET;
        end else if (phase == PH_OFFSET) begin
            mode = w.word[31:30];
            pix  = w.word[29:2];
            if (pix >= FRAME_TOTAL) begin
                raise_error(ERR_OFFSCREEN, w.fin);
            end else if (mode > MODE_RLE) begin
                raise_error(ERR_MODE, w.fin);
            end else begin
                // Frame 1 behind a moved window restarts it from scratch
                if (win_low > 1 && cur_frame == 1) begin
                    for (int i = 0; i < FRAME_SLOTS; i++) begin
                        p = slot_of(i);
                        queue_result(KIND_CLEAR, p, '0, '0, FILL_RESTART, '0, '0, ERR_NONE);
                        slot_counts[p] = '0;
                    end
                    win_low = '0;
                end
                taken = 1'b1;
                if ({1'b0, cur_frame} >= {1'b0, win_low} + 33'(FRAME_SLOTS)) begin
                    // Advance: show the newest recycled slot, then clear the recycled ones
                    new_low = cur_frame + 32'd1 - 32'(FRAME_SLOTS);
                    span    = new_low - win_low;
                    if (span > FRAME_SLOTS) span = FRAME_SLOTS;
                    p = slot_of(span - 1);
                    queue_result(KIND_SHOW, p, '0, '0, '0, win_low + span - 32'd1,
                                 slot_counts[p], ERR_NONE);
                    for (int i = 0; i < span; i++) begin
                        p = slot_of(i);
                        queue_result(KIND_CLEAR, p, '0, '0, '0, '0, '0, ERR_NONE);
                        slot_counts[p] = '0;
                    end
                    slot_base = 3'((slot_base + span) % FRAME_SLOTS);
                    win_low   = new_low;
                end else if (cur_frame < win_low) begin
                    queue_result(KIND_DROP, '0, '0, '0, '0, cur_frame, '0, ERR_NONE);
                    phase   = PH_FRAME;
                    discard = !w.fin;
                    taken   = 1'b0;
                end
                if (taken) begin
                    active_slot = slot_of(cur_frame - win_low);
                    if (slot_counts[active_slot] != CNT_MAX)
                        slot_counts[active_slot] = slot_counts[active_slot] + 16'd1;
                    wpos     = pix[18:0];
                    pkt_mode = mode;
                    run_pend = 1'b0;
                    phase    = w.fin ? PH_FRAME : PH_DATA;
                end
            end
        end else begin
            if (pkt_mode == MODE_SINGLE) begin
                run_pixels(24'd1, w.word);
            end else if (run_pend) begin
                run_pend = 1'b0;
                run_pixels(pend_count, w.word);
            end else if (w.word[7:0] == MARKER_BYTE) begin
                pend_count = w.word[31:8];
                run_pend   = 1'b1;
                if (w.fin) raise_error(ERR_MARKER, 1'b1);
            end else begin
                run_pixels(24'd1, w.word);
            end
            if (w.fin) begin
                phase    = PH_FRAME;
                run_pend = 1'b0;
            end
        end
        if (step_results.size() != 0) step_results[step_results.size() - 1].last = 1'b1;
        foreach (step_results[i]) expected_results.push_back(step_results[i]);
    endtask

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------
    task automatic add_word(input logic [31:0] word, input logic start, input logic fin);
        packet_word_t w;
        w.word  = word;
        w.start = start;
        w.fin   = fin;
        pending_words.push_back(w);
    endtask

    function automatic logic [31:0] header_offset(input logic [1:0] mode,
                                                  input logic [27:0] pix);
        return {mode, pix, 2'b00};
    endfunction

    // Mostly well-formed packets near the window, with drops, restarts, big jumps,
    // off-screen and bad-mode headers, short packets, missing starts and missing ends mixed in
    task automatic add_random_packet();
        int          pick;
        int          ndata;
        logic [31:0] frame;
        logic [31:0] word;
        logic [31:0] count;
        logic [1:0]  mode;
        logic [27:0] pix;
        bit          first;
        bit          open_end;
        pick = $urandom_range(0, 99);
        if (pick < 66) begin
            frame = frame_cursor + $urandom_range(0, 5);
        end else if (pick < 76) begin
            frame = frame_cursor - $urandom_range(1, 6);
        end else if (pick < 84) begin
            frame        = 32'd1;
            frame_cursor = $urandom_range(0, 4);
        end else if (pick < 88) begin
            frame        = $urandom;
            frame_cursor = frame - 32'd2;
        end else begin
            frame = frame_cursor + $urandom_range(6, 12);
        end
        if ($urandom_range(0, 5) == 0) frame_cursor = frame_cursor + $urandom_range(1, 3);

        first    = ($urandom_range(0, 19) != 0);
        open_end = ($urandom_range(0, 19) == 0);
        if ($urandom_range(0, 29) == 0) begin
            add_word(frame, first, 1'b1);
            return;
        end

        pick = $urandom_range(0, 19);
        if (pick == 0) mode = $urandom_range(0, 1) ? MODE_BAD_3 : MODE_BAD_2;
        else mode = (pick < 10) ? MODE_SINGLE : MODE_RLE;
        pick = $urandom_range(0, 19);
        if (pick == 0) pix = 28'($urandom_range(FRAME_TOTAL, 28'hFFFFFFF));
        else if (pick < 5) pix = 28'(FRAME_TOTAL - $urandom_range(1, 12));
        else pix = 28'($urandom_range(0, FRAME_TOTAL - 1));
        ndata = $urandom_range(0, 6);

        add_word(frame, first, 1'b0);
        add_word(header_offset(mode, pix) | 32'($urandom_range(0, 3)), 1'b0,
                 ndata == 0 && !open_end);
        for (int i = 0; i < ndata; i++) begin
            if (mode == MODE_RLE && $urandom_range(0, 2) == 0) begin
                count = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6);
                word  = {count[23:0], MARKER_BYTE};
            end else begin
                word = $urandom;
            end
            add_word(word, 1'b0, i == ndata - 1 && !open_end);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offer requests at the falling edge, in bursts with gaps
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !req_taken)) begin
            // Hold an offered request until it is taken; otherwise pick the next move
            if (gap_left != 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_words[0].word;
                s_tuser  <= pending_words[0].start;
                s_tlast  <= pending_words[0].fin;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: a rotating ready pattern, redrawn whenever its age counter runs out,
    // plus one long hold counted in its own process
    // ------------------------------------------------------------------
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    logic [7:0]  ready_pat = 8'hFF;
    int          pat_age   = 0;

    always @(negedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && req_count >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(negedge aclk) begin
        if (pat_age == 0) begin
            pat_age = 50;
            case ($urandom_range(0, 3))
                0:       ready_pat = 8'hFF;
                1:       ready_pat = 8'h11;
                default: ready_pat = 8'($urandom) | 8'h01;
            endcase
        end
        pat_age--;
        m_tready  <= (hold_left == 0) && ready_pat[0];
        ready_pat = {ready_pat[0], ready_pat[7:1]};
    end

    // ------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] result %0d: %s is 0x%0h, expected 0x%0h",
                     $realtime, results_seen, what, got, want);
    endtask

    pixel_result_t want;

    always @(posedge aclk) begin
        cycle_count++;
        req_taken = 1'b0;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (m_tuser <= KIND_ERROR) kind_seen[m_tuser]++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, kind", m_tuser, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tuser != want.kind) report_mismatch("kind", m_tuser, want.kind);
                    if (m_tdata[2:0] != want.slot) report_mismatch("slot", m_tdata[2:0], want.slot);
                    if (m_tdata[21:3] != want.pix)
                        report_mismatch("pixel_index", m_tdata[21:3], want.pix);
                    if (m_tdata[40:22] != want.len)
                        report_mismatch("run_length", m_tdata[40:22], want.len);
                    if (m_tdata[72:41] != want.value)
                        report_mismatch("pixel_value", m_tdata[72:41], want.value);
                    if (m_tdata[104:73] != want.frame)
                        report_mismatch("frame_number", m_tdata[104:73], want.frame);
                    if (m_tdata[120:105] != want.total)
                        report_mismatch("packet_total", m_tdata[120:105], want.total);
                    if (m_tdata[123:121] != want.err)
                        report_mismatch("error_code", m_tdata[123:121], want.err);
                    if (m_tdata[127:124] != 4'd0)
                        report_mismatch("pad bits", m_tdata[127:124], '0);
                    if (m_tlast != want.last) report_mismatch("last_of_run", m_tlast, want.last);
                end
            end
            // Predict only after the check: a request never answers in its own cycle
            if (s_tvalid && s_tready) begin
                track_packet_word(pending_words.pop_front());
                req_taken = 1'b1;
                req_count++;
            end
        end
    end

    // Watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    int directed_total;

    initial begin
        // Short packet: end flag on the frame word
        add_word(32'd3, 1'b1, 1'b1);
        // Frame 0, single-pixel mode at pixel 0, all-ones pixel
        add_word(32'd0, 1'b1, 1'b0);
        add_word(header_offset(MODE_SINGLE, 28'd0), 1'b0, 1'b0);
        add_word(32'hFFFF_FFFF, 1'b0, 1'b1);
        // Run mode near the frame end: maximal repeat clipped, then nothing left,
        // then a marker on the last word
        add_word(32'd2, 1'b1, 1'b0);
        add_word(header_offset(MODE_RLE, 28'(FRAME_TOTAL - 3)), 1'b0, 1'b0);
        add_word({24'hFF_FFFF, MARKER_BYTE}, 1'b0, 1'b0);
        add_word(32'hA5A5_A5A5, 1'b0, 1'b0);
        add_word(32'h1234_5678, 1'b0, 1'b0);
        add_word({24'h00_0000, MARKER_BYTE}, 1'b0, 1'b1);
        // Zero repeat gives nothing, a repeat of one gives a single pixel
        add_word(32'd1, 1'b1, 1'b0);
        add_word(header_offset(MODE_RLE, 28'd10), 1'b0, 1'b0);
        add_word({24'h00_0000, MARKER_BYTE}, 1'b0, 1'b0);
        add_word(32'h5A5A_5A5A, 1'b0, 1'b0);
        add_word({24'h00_0001, MARKER_BYTE}, 1'b0, 1'b0);
        add_word(32'h0000_0000, 1'b0, 1'b1);
        // Off screen at the largest offset; the rest of the packet is dropped
        add_word(32'd0, 1'b1, 1'b0);
        add_word(32'h3FFF_FFFF, 1'b0, 1'b0);
        add_word(32'hDEAD_BEEF, 1'b0, 1'b1);
        // Bad mode, ending on the offset word
        add_word(32'd0, 1'b1, 1'b0);
        add_word(header_offset(MODE_BAD_2, 28'd5), 1'b0, 1'b1);
        // Advance past a full window, then write the last pixel of the frame
        add_word(32'd9, 1'b1, 1'b0);
        add_word(header_offset(MODE_SINGLE, 28'(FRAME_TOTAL - 1)), 1'b0, 1'b0);
        add_word(32'h0000_0001, 1'b0, 1'b1);
        // Frame older than the window
        add_word(32'd2, 1'b1, 1'b0);
        add_word(header_offset(MODE_SINGLE, 28'd0), 1'b0, 1'b1);
        // Frame 1 after the window moved: restart
        add_word(32'd1, 1'b1, 1'b0);
        add_word(header_offset(MODE_SINGLE, 28'd1), 1'b0, 1'b1);
        directed_total = pending_words.size();

        while (pending_words.size() < directed_total + RANDOM_REQUESTS) begin
            if ($urandom_range(0, 19) == 0)
                add_word($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else
                add_random_packet();
        end

        // Drain: every request taken and every result seen, then an idle wait before the final check
        while (pending_words.size() != 0 || expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0)
            report_mismatch("results still missing", expected_results.size(), '0);

        $display("Drove %0d packet words; checked %0d results in %0d cycles",
                 req_count, results_seen, cycle_count);
        $display("runs %0d, clears %0d, shows %0d, drops %0d, errors %0d; mismatches %0d",
                 kind_seen[KIND_RUN], kind_seen[KIND_CLEAR], kind_seen[KIND_SHOW],
                 kind_seen[KIND_DROP], kind_seen[KIND_ERROR], mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
